FILE: design/tsd_pkg.sv
// Package of widths, codes and controller/datapath types for the turn segment detector.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

   localparam int ANGLE_W    = 17;
   localparam int MAG_W      = 17;
   localparam int STORE_W    = 18;
   localparam int SUM_W      = 25;
   localparam int THR_W      = 16;
   localparam int CAP_W      = 10;
   localparam int CURVE_W    = 16;
   localparam int IDX_W      = 24;
   localparam int LEN_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   localparam int MIN_RUN = 4;

   localparam logic [THR_W-1:0] DEFAULT_THR     = 16'd512;
   localparam logic [SUM_W-1:0] DEFAULT_MIN_TOT = 25'd5120;
   localparam logic [CAP_W-1:0] DEFAULT_CAP     = 10'd360;
   localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_TURN_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TOTAL      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY_LIMIT = 2'd2;

   localparam logic KIND_TURN     = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FETCH,
      ST_SEARCH,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic capture;
      logic step;
      logic walk_start;
      logic fetch;
      logic walk_step;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic qualify;
      logic overflow;
      logic out_free;
      logic found;
   } status_type;

endpackage

`default_nettype wire

FILE: design/tsd_channels.sv
// Valid/ready channel interfaces for the sample input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface tsd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tsd_pkg::ANGLE_W-1:0]  angle;
   logic                                end_of_stream;

   modport source (output valid, output angle, output end_of_stream, input ready);
   modport sink   (input valid, input angle, input end_of_stream, output ready);
endinterface

interface tsd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [tsd_pkg::CURVE_W-1:0]  curve_number;
   logic [tsd_pkg::IDX_W-1:0]    peak_index;
   logic [tsd_pkg::LEN_W-1:0]    run_length;
   logic [tsd_pkg::SUM_W-1:0]    turn_total;

   modport source (output valid, output kind, output curve_number, output peak_index,
                   output run_length, output turn_total, input ready);
   modport sink   (input valid, input kind, input curve_number, input peak_index,
                   input run_length, input turn_total, output ready);
endinterface

`default_nettype wire

FILE: design/tsd_datapath.sv
// Datapath: configuration, run state, sample store, peak walk and result register.
`timescale 1ns / 1ps
`default_nettype none

module tsd_datapath #(
   parameter int BUF_DEPTH = 512
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tsd_pkg::cmd_type                     cmd,
   output tsd_pkg::status_type                       status,
   input  wire logic                                 csr_we,
   input  wire logic [tsd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [tsd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic signed [tsd_pkg::ANGLE_W-1:0]   req_angle,
   input  wire logic                                 req_end_of_stream,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_valid,
   output logic                                      rsp_kind,
   output logic [tsd_pkg::CURVE_W-1:0]               rsp_curve_number,
   output logic [tsd_pkg::IDX_W-1:0]                 rsp_peak_index,
   output logic [tsd_pkg::LEN_W-1:0]                 rsp_run_length,
   output logic [tsd_pkg::SUM_W-1:0]                 rsp_turn_total
);
   import tsd_pkg::*;

   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   localparam int AW    = $clog2(BUF_DEPTH);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BUF_DEPTH);

   logic [THR_W-1:0]         thr_ff;
   logic [SUM_W-1:0]         min_total_ff;
   logic [CAP_W-1:0]         cap_ff;

   logic signed [ANGLE_W-1:0] angle_ff;
   logic                     eos_ff;

   logic                     in_run_ff, in_run_in;
   logic                     run_pos_ff, run_pos_in;
   logic [CNT_W-1:0]         run_count_ff, run_count_in;
   logic [SUM_W-1:0]         run_sum_ff, run_sum_in;
   logic [IDX_W-1:0]         sample_ff, sample_in;
   logic [CURVE_W-1:0]       turns_ff, turns_in;
   logic                     halted_ff, halted_in;

   logic [AW-1:0]            ptr_ff, ptr_in;
   logic [CNT_W-1:0]         k_ff, k_in;
   logic [SUM_W-1:0]         prefix_ff, prefix_in;
   logic [STORE_W-1:0]       rd_data_ff;
   logic [STORE_W-1:0]       run_store_mem [BUF_DEPTH];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     kind_ff, kind_in;
   logic [CURVE_W-1:0]       curve_ff, curve_in;
   logic [IDX_W-1:0]         peak_ff, peak_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [SUM_W-1:0]         total_ff, total_in;

   logic [ANGLE_W-1:0]       angle_u;
   logic                     neg;
   logic                     pos;
   logic [MAG_W-1:0]         mag;
   logic [THR_W-1:0]         thr_eff;
   logic                     open_run;
   logic                     active;
   logic                     sign_ref;
   logic                     close_run;
   logic                     append;
   logic [CNT_W-1:0]         cnt_inc;
   logic [SUM_W:0]           sum_wide;
   logic [SUM_W-1:0]         sum_sat;
   logic [CMP_W-1:0]         cap_ext;
   logic [CMP_W-1:0]         cap_eff;
   logic [CMP_W-1:0]         len_ext;
   logic                     overflow;
   logic                     qualify;
   logic [SUM_W-1:0]         prefix_next;
   logic                     found;
   logic                     out_free;
   logic                     mem_we;
   logic                     finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= DEFAULT_THR;
         min_total_ff <= DEFAULT_MIN_TOT;
         cap_ff       <= DEFAULT_CAP;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TURN_THRESHOLD: thr_ff       <= csr_wdata[THR_W-1:0];
            CSR_MIN_TOTAL:      min_total_ff <= csr_wdata[SUM_W-1:0];
            CSR_CAPACITY_LIMIT: cap_ff       <= csr_wdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         angle_ff <= req_angle;
         eos_ff   <= req_end_of_stream;
      end
   end

   always_comb begin
      angle_u   = $unsigned(angle_ff);
      neg       = angle_u[ANGLE_W-1];
      pos       = !neg && (angle_u != '0);
      mag       = neg ? (~angle_u + MAG_W'(1)) : angle_u;
      thr_eff   = (thr_ff == '0) ? DEFAULT_THR : thr_ff;
      open_run  = !in_run_ff && (mag > MAG_W'(thr_eff));
      active    = in_run_ff || open_run;
      sign_ref  = in_run_ff ? run_pos_ff : pos;
      close_run = active && (({mag, 1'b0} < (MAG_W + 1)'(thr_eff)) || (pos != sign_ref));
      append    = active && !close_run;
      cnt_inc   = run_count_ff + CNT_W'(1);
      sum_wide  = {1'b0, run_sum_ff} + (SUM_W + 1)'(mag);
      sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      cap_ext   = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > DEPTH_C) begin
         cap_eff = DEPTH_C;
      end else begin
         cap_eff = cap_ext;
      end
      overflow  = !halted_ff && append && (CMP_W'(cnt_inc) >= cap_eff);
      qualify   = !halted_ff && close_run && (CMP_W'(run_count_ff) >= CMP_W'(MIN_RUN))
                  && (run_sum_ff >= min_total_ff);
      prefix_next = prefix_ff + SUM_W'(rd_data_ff);
      found     = {prefix_next, 1'b0} >= {1'b0, run_sum_ff};
      out_free  = !rsp_valid_ff || rsp_ready;
      mem_we    = cmd.step && !halted_ff && append;
      finish    = (cmd.step && !halted_ff) || cmd.report;
   end

   assign status = '{qualify: qualify, overflow: overflow, out_free: out_free, found: found};

   always_comb begin
      in_run_in    = in_run_ff;
      run_pos_in   = run_pos_ff;
      run_count_in = run_count_ff;
      run_sum_in   = run_sum_ff;
      sample_in    = sample_ff;
      turns_in     = turns_ff;
      halted_in    = halted_ff;
      if (cmd.step && !halted_ff) begin
         if (open_run) begin
            in_run_in  = 1'b1;
            run_pos_in = pos;
         end
         if (close_run) begin
            in_run_in    = 1'b0;
            run_count_in = '0;
            run_sum_in   = '0;
         end else if (append) begin
            run_count_in = cnt_inc;
            run_sum_in   = sum_sat;
            if (overflow) begin
               halted_in = 1'b1;
            end
         end
      end
      if (cmd.report) begin
         in_run_in    = 1'b0;
         run_count_in = '0;
         run_sum_in   = '0;
         turns_in     = turns_ff + CURVE_W'(1);
      end
      if ((cmd.step || cmd.report) && eos_ff) begin
         in_run_in    = 1'b0;
         run_pos_in   = 1'b0;
         run_count_in = '0;
         run_sum_in   = '0;
         sample_in    = '0;
         turns_in     = '0;
         halted_in    = 1'b0;
      end else if (finish) begin
         sample_in = sample_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff    <= 1'b0;
         run_pos_ff   <= 1'b0;
         run_count_ff <= '0;
         run_sum_ff   <= '0;
         sample_ff    <= '0;
         turns_ff     <= '0;
         halted_ff    <= 1'b0;
      end else begin
         in_run_ff    <= in_run_in;
         run_pos_ff   <= run_pos_in;
         run_count_ff <= run_count_in;
         run_sum_ff   <= run_sum_in;
         sample_ff    <= sample_in;
         turns_ff     <= turns_in;
         halted_ff    <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         run_store_mem[run_count_ff[AW-1:0]] <= STORE_W'(mag);
      end
      rd_data_ff <= run_store_mem[ptr_ff];
   end

   always_comb begin
      ptr_in    = ptr_ff;
      k_in      = k_ff;
      prefix_in = prefix_ff;
      if (cmd.walk_start) begin
         ptr_in    = '0;
         k_in      = '0;
         prefix_in = '0;
      end else if (cmd.fetch) begin
         ptr_in = ptr_ff + AW'(1);
      end else if (cmd.walk_step && !found) begin
         ptr_in    = ptr_ff + AW'(1);
         k_in      = k_ff + CNT_W'(1);
         prefix_in = prefix_next;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      k_ff      <= k_in;
      prefix_ff <= prefix_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      curve_in     = curve_ff;
      peak_in      = peak_ff;
      len_in       = len_ff;
      total_in     = total_ff;
      len_ext      = CMP_W'(cnt_inc);
      if (cmd.report) begin
         len_ext      = CMP_W'(run_count_ff);
         rsp_valid_in = 1'b1;
         kind_in      = KIND_TURN;
         curve_in     = turns_ff;
         peak_in      = sample_ff + IDX_W'(k_ff) - IDX_W'(run_count_ff);
         len_in       = len_ext[LEN_W-1:0];
         total_in     = run_sum_ff;
      end else if (cmd.step && overflow) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_OVERFLOW;
         curve_in     = turns_ff;
         peak_in      = sample_ff;
         len_in       = len_ext[LEN_W-1:0];
         total_in     = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      curve_ff <= curve_in;
      peak_ff  <= peak_in;
      len_ff   <= len_in;
      total_ff <= total_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_curve_number = curve_ff;
   assign rsp_peak_index   = peak_ff;
   assign rsp_run_length   = len_ff;
   assign rsp_turn_total   = total_ff;

   // Outside a run there is nothing counted or summed.
   a_idle_run_empty: assert property (@(posedge clock) disable iff (reset)
      !in_run_ff |-> (run_count_ff == '0 && run_sum_ff == '0))
      else $error("run count or sum left over outside a run");

   // The half-total point always lies inside the stored run.
   a_walk_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (k_ff < run_count_ff))
      else $error("peak walk ran past the end of the run");

   a_overflow_halts: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && overflow && !eos_ff) |=> halted_ff)
      else $error("overflow reported without halting");

endmodule

`default_nettype wire

FILE: design/tsd_controller.sv
// Controller: sequences capture and evaluation of each sample, and store walk and report of a qualifying run.
`timescale 1ns / 1ps
`default_nettype none

module tsd_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire tsd_pkg::status_type  status,
   output tsd_pkg::cmd_type          cmd
);
   import tsd_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.qualify) begin
               state_in = ST_FETCH;
            end else if (!status.overflow || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (status.found) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EVAL: begin
            cmd.walk_start = status.qualify;
            cmd.step       = !status.qualify && (!status.overflow || status.out_free);
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_SEARCH: begin
            cmd.walk_step = 1'b1;
         end
         ST_REPORT: begin
            cmd.report = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL))
      else $error("accepted sample not evaluated in the next cycle");

   a_report_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT && !status.out_free) |=> (state_ff == ST_REPORT))
      else $error("report dropped while the result register was full");

endmodule

`default_nettype wire

FILE: design/turn_segment_detector.sv
// Top level of the turn segment detector: controller, datapath and channel wiring.
//
//   channel   direction   handshake             payload
//   req_chan  in          valid/ready           angle, end_of_stream
//   rsp_chan  out         valid/ready           kind, curve_number, peak_index,
//                                               run_length, turn_total
//   csr_*     in          csr_we, no back-pressure  csr_index, csr_wdata
//
// Each sample is captured and then evaluated; req_chan is ready only while idle. A sample that
// closes a reported turn then passes fetch, search and report, the search walking the store
// one entry a cycle through its single read port to the half-total position within the run.
// Reset is synchronous and resets config, run and handshake state; the store is not cleared.
// A result waiting on rsp_chan stalls work only when another result must be written.
`timescale 1ns / 1ps
`default_nettype none

module turn_segment_detector #(
   parameter int BUF_DEPTH = 512
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tsd_req_if.sink                              req_chan,
   tsd_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [tsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsd_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   tsd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsd_datapath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_angle         (req_chan.angle),
      .req_end_of_stream (req_chan.end_of_stream),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_kind          (rsp_chan.kind),
      .rsp_curve_number  (rsp_chan.curve_number),
      .rsp_peak_index    (rsp_chan.peak_index),
      .rsp_run_length    (rsp_chan.run_length),
      .rsp_turn_total    (rsp_chan.turn_total)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire
